FILE: rtl/core/rc4_stream_cipher_assert.svh
// Assertion macros for the RC4 stream cipher core.
// Used by rc4_stream_cipher.sv; expects clk_i and rst_ni in the including scope.
`ifndef RC4_STREAM_CIPHER_ASSERT_SVH
`define RC4_STREAM_CIPHER_ASSERT_SVH

`ifndef SYNTHESIS
// Plain property check, clocked on clk_i, off while in reset
`define RC4_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Antecedent this cycle implies consequent in the next cycle
`define RC4_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RC4_ASSERT(lbl, prop, msg)
`define RC4_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/core/rc4_pkg.sv
// Shared types and constants for the RC4 stream cipher core.
// No dependencies; used by rc4_sbox_ram and rc4_stream_cipher.
package rc4_pkg;

  localparam int PermLength  = 256;
  localparam int PermAw      = 8;
  localparam int MaxKeyBytes = 16;
  localparam int KeyIdxW     = 4;
  localparam int KeyLenW     = 5;
  localparam int KeyWordW    = 64;
  localparam int CfgIdxW     = 2;

  localparam logic [PermAw-1:0] ByteMax = 8'hFF;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgKeyLow    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgKeyHigh   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgKeyLength = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KS_INIT,
    ST_KS_RD_N,
    ST_KS_RD_J,
    ST_KS_WR_N,
    ST_KS_WR_J,
    ST_B_RD_I,
    ST_B_RD_J,
    ST_B_WR_I,
    ST_B_WR_J
  } rc4_state_e;

  // One write port and one read port of the permutation memory
  typedef struct packed {
    logic              we;
    logic [PermAw-1:0] waddr;
    logic [PermAw-1:0] wdata;
    logic [PermAw-1:0] raddr;
  } sbox_req_t;

endpackage

FILE: rtl/core/rc4_sbox_ram.sv
// 256 x 8 permutation memory: one write port, one read port, registered read data.
// Depends on rc4_pkg for the request struct and sizes.
module rc4_sbox_ram (
  input  logic                           clk_i,
  input  rc4_pkg::sbox_req_t             req_i,
  output logic [rc4_pkg::PermAw-1:0]     rdata_o
);

  logic [rc4_pkg::PermAw-1:0] mem [rc4_pkg::PermLength];
  logic [rc4_pkg::PermAw-1:0] rdata_q;

  // read returns the old contents on an address collision
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/rc4_stream_cipher.sv
// RC4 stream cipher core: sequencer, shared 8-bit adder, key registers.
// Depends on rc4_pkg, rc4_sbox_ram and rc4_stream_cipher_assert.svh.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries data_in_i and message_start_i.
//   Output channel (out_valid_o / out_stall_i) carries data_out_o, one byte per input.
//   Config channel (cfg_valid_i / cfg_ready_o) writes key_low (0), key_high (1),
//   key length (2); other indexes are ignored. Write only while the core is idle.
// Byte sequence:
//   A byte of a running message passes through ST_B_RD_J, ST_B_WR_I and ST_B_WR_J;
//   its result is then registered, and the next byte is taken once the sequencer
//   is back in ST_IDLE. The permutation memory port (one read and one write per
//   cycle) sets this pace. A start byte, or the first byte after reset, first runs the
//   key schedule: an identity fill of all 256 entries, then 256 swaps through
//   ST_KS_RD_N, ST_KS_RD_J, ST_KS_WR_N and ST_KS_WR_J, before its own swap.
// Reset:
//   Clears indexes, the keyed flag and the output valid flag; key = 0, length 16.
//   The permutation memory is not cleared; the key schedule fills it first.
// Stall:
//   A finished byte waits in the output register; the core takes the next
//   input meanwhile and holds its own result until the output register frees.

`include "rc4_stream_cipher_assert.svh"

module rc4_stream_cipher (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input transactions
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      data_in_i,
  input  logic                            message_start_i,
  // output transactions
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      data_out_o,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rc4_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [rc4_pkg::KeyWordW-1:0]    cfg_data_i
);

  rc4_pkg::rc4_state_e state_q, state_d;

  logic [rc4_pkg::PermAw-1:0]    n_q, n_d;
  logic [rc4_pkg::KeyIdxW-1:0]   kidx_q, kidx_d;
  logic [rc4_pkg::PermAw-1:0]    index_i_q, index_i_d;
  logic [rc4_pkg::PermAw-1:0]    index_j_q, index_j_d;
  logic [rc4_pkg::PermAw-1:0]    si_q, si_d;
  logic [rc4_pkg::PermAw-1:0]    sj_q, sj_d;
  logic [rc4_pkg::PermAw-1:0]    k_q, k_d;
  logic [7:0]                    data_q, data_d;
  logic                          keyed_q, keyed_d;
  logic                          out_valid_q, out_valid_d;
  logic [7:0]                    data_out_q, data_out_d;

  logic [rc4_pkg::KeyWordW-1:0]  key_low_q, key_high_q;
  logic [rc4_pkg::KeyLenW-1:0]   key_len_q;

  logic [rc4_pkg::KeyLenW-1:0]   eff_len;
  logic [rc4_pkg::KeyLenW-1:0]   last_kidx;
  logic [2*rc4_pkg::KeyWordW-1:0] key_bytes;
  logic [7:0]                    key_byte;

  logic [rc4_pkg::PermAw-1:0]    add_a, add_b, add_c, add_sum;
  logic [rc4_pkg::PermAw-1:0]    ks_byte;
  logic [rc4_pkg::PermAw-1:0]    mem_rdata;
  rc4_pkg::sbox_req_t            mem_req;
  logic                          in_acc;
  logic                          out_free;

  // permutation memory
  rc4_sbox_ram u_sbox (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      key_len_q  <= rc4_pkg::KeyLenW'(rc4_pkg::MaxKeyBytes);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rc4_pkg::CfgKeyLow:    key_low_q  <= cfg_data_i;
        rc4_pkg::CfgKeyHigh:   key_high_q <= cfg_data_i;
        rc4_pkg::CfgKeyLength: key_len_q  <= cfg_data_i[rc4_pkg::KeyLenW-1:0];
        default: ;
      endcase
    end
  end

  // effective key length: zero reads as one, saturate at the maximum
  always_comb begin
    eff_len = key_len_q;
    if (key_len_q == '0) begin
      eff_len = rc4_pkg::KeyLenW'(1);
    end else if (key_len_q > rc4_pkg::KeyLenW'(rc4_pkg::MaxKeyBytes)) begin
      eff_len = rc4_pkg::KeyLenW'(rc4_pkg::MaxKeyBytes);
    end
  end

  assign last_kidx = eff_len - rc4_pkg::KeyLenW'(1);
  assign key_bytes = {key_high_q, key_low_q};
  assign key_byte  = key_bytes[{kidx_q, 3'b000} +: 8];

  // shared 8-bit adder, operands chosen by the sequencer
  assign add_sum = add_a + add_b + add_c;

  // keystream byte, forwarding the swapped entries
  always_comb begin
    if (k_q == index_j_q) begin
      ks_byte = si_q;
    end else if (k_q == index_i_q) begin
      ks_byte = sj_q;
    end else begin
      ks_byte = mem_rdata;
    end
  end

  assign in_stall_o = (state_q != rc4_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !(out_valid_q && out_stall_i);

  // sequencer: next state, memory requests, datapath updates
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    kidx_d      = kidx_q;
    index_i_d   = index_i_q;
    index_j_d   = index_j_q;
    si_d        = si_q;
    sj_d        = sj_q;
    k_d         = k_q;
    data_d      = data_q;
    keyed_d     = keyed_q;
    out_valid_d = out_valid_q && out_stall_i;
    data_out_d  = data_out_q;

    mem_req.we    = 1'b0;
    mem_req.waddr = n_q;
    mem_req.wdata = n_q;
    mem_req.raddr = index_i_q + 8'd1;

    add_a = index_j_q;
    add_b = mem_rdata;
    add_c = '0;

    unique case (state_q)
      rc4_pkg::ST_IDLE: begin
        // read S[i+1] ahead so a keyed byte can go straight on
        if (in_acc) begin
          data_d = data_in_i;
          if (message_start_i || !keyed_q) begin
            n_d     = '0;
            state_d = rc4_pkg::ST_KS_INIT;
          end else begin
            state_d = rc4_pkg::ST_B_RD_J;
          end
        end
      end
      rc4_pkg::ST_KS_INIT: begin
        // identity fill
        mem_req.we = 1'b1;
        n_d        = n_q + 8'd1;
        if (n_q == rc4_pkg::ByteMax) begin
          index_j_d = '0;
          kidx_d    = '0;
          state_d   = rc4_pkg::ST_KS_RD_N;
        end
      end
      rc4_pkg::ST_KS_RD_N: begin
        mem_req.raddr = n_q;
        state_d       = rc4_pkg::ST_KS_RD_J;
      end
      rc4_pkg::ST_KS_RD_J: begin
        // j += S[n] + key[n mod len]
        add_c         = key_byte;
        index_j_d     = add_sum;
        si_d          = mem_rdata;
        mem_req.raddr = add_sum;
        state_d       = rc4_pkg::ST_KS_WR_N;
      end
      rc4_pkg::ST_KS_WR_N: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = n_q;
        mem_req.wdata = mem_rdata;
        state_d       = rc4_pkg::ST_KS_WR_J;
      end
      rc4_pkg::ST_KS_WR_J: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = index_j_q;
        mem_req.wdata = si_q;
        n_d           = n_q + 8'd1;
        kidx_d        = (kidx_q == last_kidx[rc4_pkg::KeyIdxW-1:0]) ? '0 : kidx_q + 4'd1;
        if (n_q == rc4_pkg::ByteMax) begin
          index_i_d = '0;
          index_j_d = '0;
          keyed_d   = 1'b1;
          state_d   = rc4_pkg::ST_B_RD_I;
        end else begin
          state_d   = rc4_pkg::ST_KS_RD_N;
        end
      end
      rc4_pkg::ST_B_RD_I: begin
        state_d = rc4_pkg::ST_B_RD_J;
      end
      rc4_pkg::ST_B_RD_J: begin
        // i += 1, j += S[i]
        index_i_d     = index_i_q + 8'd1;
        index_j_d     = add_sum;
        si_d          = mem_rdata;
        mem_req.raddr = add_sum;
        state_d       = rc4_pkg::ST_B_WR_I;
      end
      rc4_pkg::ST_B_WR_I: begin
        // S[i] = S[j]; k = S[i] + S[j]
        mem_req.we    = 1'b1;
        mem_req.waddr = index_i_q;
        mem_req.wdata = mem_rdata;
        sj_d          = mem_rdata;
        add_a         = si_q;
        k_d           = add_sum;
        mem_req.raddr = add_sum;
        state_d       = rc4_pkg::ST_B_WR_J;
      end
      rc4_pkg::ST_B_WR_J: begin
        // S[j] = old S[i]; hold here until the output register is free
        mem_req.we    = 1'b1;
        mem_req.waddr = index_j_q;
        mem_req.wdata = si_q;
        mem_req.raddr = k_q;
        if (out_free) begin
          out_valid_d = 1'b1;
          data_out_d  = data_q ^ ks_byte;
          state_d     = rc4_pkg::ST_IDLE;
        end
      end
      default: state_d = rc4_pkg::ST_IDLE;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rc4_pkg::ST_IDLE;
      n_q         <= '0;
      kidx_q      <= '0;
      index_i_q   <= '0;
      index_j_q   <= '0;
      keyed_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      kidx_q      <= kidx_d;
      index_i_q   <= index_i_d;
      index_j_q   <= index_j_d;
      keyed_q     <= keyed_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    si_q       <= si_d;
    sj_q       <= sj_d;
    k_q        <= k_d;
    data_q     <= data_d;
    data_out_q <= data_out_d;
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = data_out_q;

  // checks
  `RC4_ASSERT_NEXT(a_rekey_on_start,
    in_acc && (message_start_i || !keyed_q),
    state_q == rc4_pkg::ST_KS_INIT,
    "start byte did not enter key schedule")
  `RC4_ASSERT_NEXT(a_keyed_byte_fast,
    in_acc && !message_start_i && keyed_q,
    state_q == rc4_pkg::ST_B_RD_J,
    "keyed byte did not go straight to the swap")
  `RC4_ASSERT_NEXT(a_ks_done,
    state_q == rc4_pkg::ST_KS_WR_J && n_q == rc4_pkg::ByteMax,
    keyed_q && index_i_q == '0 && index_j_q == '0,
    "key schedule end left indexes or flag wrong")
  `RC4_ASSERT(a_we_states,
    mem_req.we |-> (state_q == rc4_pkg::ST_KS_INIT || state_q == rc4_pkg::ST_KS_WR_N ||
                    state_q == rc4_pkg::ST_KS_WR_J || state_q == rc4_pkg::ST_B_WR_I ||
                    state_q == rc4_pkg::ST_B_WR_J),
    "memory write outside a write state")
  `RC4_ASSERT_NEXT(a_result_load,
    state_q == rc4_pkg::ST_B_WR_J && out_free,
    out_valid_q && state_q == rc4_pkg::ST_IDLE,
    "finished byte not moved to the output register")

endmodule
